// ===== sv/rmmm_pkg.sv =====
// ----------------------------------------------------------------------------
// rmmm_pkg
// Shared command type for the running min / max / mean block.
// ----------------------------------------------------------------------------
package rmmm_pkg;

  // Commands from the controller to the datapath, one per cycle at most.
  typedef struct packed {
    logic load;    // take a sample, update last / min / max / count, form difference
    logic abs;     // replace difference by its magnitude, clear remainder
    logic step;    // one restoring division step
    logic finish;  // apply quotient to mean, load output register
  } rmmm_cmd_t;

endpackage : rmmm_pkg

// ===== sv/rmmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmmm_ctrl
// Sequencer: accept a sample, run the divider, then hand off the result.
// ----------------------------------------------------------------------------
module rmmm_ctrl #(
  parameter int DIV_STEPS = 49
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rmmm_pkg::rmmm_cmd_t cmd_o
);
  import rmmm_pkg::*;

  localparam int CntW = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ABS,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  logic            fin_go;

  // Finish only when the output register is free or is draining this cycle.
  assign fin_go = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.abs    = (state_q == ST_ABS);
    cmd_o.step   = (state_q == ST_DIV);
    cmd_o.finish = fin_go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_ABS;
          end
        end
        ST_ABS: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_q == CntW'(DIV_STEPS - 1)) begin
            state_q <= ST_FIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule : rmmm_ctrl

// ===== sv/rmmm_datapath.sv =====
// ----------------------------------------------------------------------------
// rmmm_datapath
// Statistic registers, radix-2 restoring divider and output register.
// ----------------------------------------------------------------------------
module rmmm_datapath #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rmmm_pkg::rmmm_cmd_t                   cmd_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_i,
  output logic signed [SAMPLE_WIDTH-1:0]        current_value_o,
  output logic signed [SAMPLE_WIDTH-1:0]        minimum_o,
  output logic signed [SAMPLE_WIDTH-1:0]        maximum_o,
  output logic signed [SAMPLE_WIDTH+FRAC_BITS-1:0] mean_o,
  output logic [COUNT_WIDTH-1:0]                sample_count_o
);
  import rmmm_pkg::*;

  localparam int MW = SAMPLE_WIDTH + FRAC_BITS;
  localparam int DW = MW + 1;
  localparam int CW = COUNT_WIDTH;

  logic signed [SAMPLE_WIDTH-1:0] last_q, low_q, high_q;
  logic signed [MW-1:0]           mean_q, mean_d;
  logic [CW-1:0]                  seen_q;
  logic [DW-1:0]                  dvd_q;
  logic [CW-1:0]                  rem_q;
  logic                           neg_q;

  logic                           first;
  logic signed [DW-1:0]           diff;
  logic [CW:0]                    shifted;
  logic                           ge;

  assign first   = (seen_q == '0);
  assign diff    = (DW'(sample_i) <<< FRAC_BITS) - DW'(mean_q);
  assign shifted = {rem_q, dvd_q[DW-1]};
  assign ge      = (shifted >= {1'b0, seen_q});
  assign mean_d  = neg_q ? (mean_q - $signed(dvd_q[MW-1:0]))
                         : (mean_q + $signed(dvd_q[MW-1:0]));

  // Statistic state; reset to zero as the running totals are control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      low_q  <= '0;
      high_q <= '0;
      mean_q <= '0;
      seen_q <= '0;
    end else begin
      if (cmd_i.load) begin
        last_q <= sample_i;
        if (first || (sample_i < low_q)) begin
          low_q <= sample_i;
        end
        if (first || (sample_i > high_q)) begin
          high_q <= sample_i;
        end
        if (seen_q != '1) begin
          seen_q <= seen_q + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        mean_q <= mean_d;
      end
    end
  end

  // Divider: dividend shifts out at the top, quotient bits shift in below.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dvd_q <= diff;
      neg_q <= diff[DW-1];
    end else if (cmd_i.abs) begin
      dvd_q <= neg_q ? (~dvd_q + 1'b1) : dvd_q;
      rem_q <= '0;
    end else if (cmd_i.step) begin
      dvd_q <= {dvd_q[DW-2:0], ge};
      rem_q <= ge ? CW'(shifted - {1'b0, seen_q}) : shifted[CW-1:0];
    end
  end

  // Output register: hold until taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      current_value_o <= last_q;
      minimum_o       <= low_q;
      maximum_o       <= high_q;
      mean_o          <= mean_d;
      sample_count_o  <= seen_q;
    end
  end

endmodule : rmmm_datapath

// ===== sv/running_min_max_mean.sv =====
// ----------------------------------------------------------------------------
// running_min_max_mean
// Running last value, minimum, maximum, saturating count and incremental mean.
// ----------------------------------------------------------------------------
// Sequence: a sample beat is accepted, its difference from the mean is made a
//   magnitude, one radix-2 divider step runs per quotient bit, then finish
//   loads the result beat. A new sample is accepted only once the previous one
//   has finished. A result beat left waiting holds the finish.
// Reset: rst_ni clears all statistics to zero and empties the output register;
//   the block is ready for a sample straight out of reset.
// ----------------------------------------------------------------------------
module running_min_max_mean #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  // sample beat
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: sample
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  // result beat
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata: current_value, minimum, maximum, mean, sample_count
  output logic [((4*SAMPLE_WIDTH+FRAC_BITS+COUNT_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
  import rmmm_pkg::*;

  localparam int MW     = SAMPLE_WIDTH + FRAC_BITS;
  localparam int OUT_W  = 3*SAMPLE_WIDTH + MW + COUNT_WIDTH;
  localparam int OUT_TW = ((OUT_W + 7)/8)*8;
  // One quotient bit per step over the sign-magnitude difference.
  localparam int DIV_STEPS = MW + 1;

  rmmm_cmd_t                      cmd;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic signed [SAMPLE_WIDTH-1:0] current_value, minimum, maximum;
  logic signed [MW-1:0]           mean;
  logic [COUNT_WIDTH-1:0]         sample_count;

  // Take the sample from the low bits; padding above is ignored.
  assign sample = $signed(s_axis_tdata[SAMPLE_WIDTH-1:0]);

  // Sequencer: idle -> magnitude -> divide -> finish.
  rmmm_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Statistics, divider and output register.
  rmmm_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sample_i        (sample),
    .current_value_o (current_value),
    .minimum_o       (minimum),
    .maximum_o       (maximum),
    .mean_o          (mean),
    .sample_count_o  (sample_count)
  );

  // Pack fields from the lowest bit up; zero-fill to a whole byte.
  assign m_axis_tdata = OUT_TW'({sample_count, mean, maximum, minimum, current_value});

endmodule : running_min_max_mean

// ===== sv/rmmm_checker.sv =====
// ----------------------------------------------------------------------------
// rmmm_checker
// Port-level checks of the running min / max / mean block.
// ----------------------------------------------------------------------------
module rmmm_checker #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16,
  parameter int COUNT_WIDTH  = 32
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((4*SAMPLE_WIDTH+FRAC_BITS+COUNT_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
  localparam int SW = SAMPLE_WIDTH;
  localparam int MW = SAMPLE_WIDTH + FRAC_BITS;

  logic signed [SW-1:0]   cur_w, min_w, max_w;
  logic signed [MW-1:0]   mean_w, lo_s, hi_s;
  logic [COUNT_WIDTH-1:0] cnt_w;

  assign cur_w  = $signed(m_axis_tdata[SW-1:0]);
  assign min_w  = $signed(m_axis_tdata[2*SW-1:SW]);
  assign max_w  = $signed(m_axis_tdata[3*SW-1:2*SW]);
  assign mean_w = $signed(m_axis_tdata[3*SW+MW-1:3*SW]);
  assign cnt_w  = m_axis_tdata[3*SW+MW+COUNT_WIDTH-1:3*SW+MW];
  assign lo_s   = MW'(min_w) <<< FRAC_BITS;
  assign hi_s   = MW'(max_w) <<< FRAC_BITS;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // One sample at a time: no second accept right after one.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("sample accepted while previous one in progress");

  // Every result counts at least the sample it reports.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_w != '0)
    else $error("result with zero sample count");

  // The last sample lies between minimum and maximum.
  a_cur_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (min_w <= cur_w) && (cur_w <= max_w))
    else $error("current value outside min/max");

  // The mean never leaves the min/max window.
  a_mean_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (lo_s <= mean_w) && (mean_w <= hi_s))
    else $error("mean outside min/max");

endmodule : rmmm_checker

bind running_min_max_mean rmmm_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH),
  .FRAC_BITS    (FRAC_BITS),
  .COUNT_WIDTH  (COUNT_WIDTH)
) u_rmmm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
